// File: src/bmhq_pkg.sv
package bmhq_pkg;

  localparam int unsigned KeyW    = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 7;

  typedef logic signed [KeyW-1:0] key_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Broadcast from the top level to every cell in a cycle.
  typedef struct packed {
    logic ins;
    logic rem;
    key_t key;
  } cmd_t;

  // What a cell shows its neighbours.
  typedef struct packed {
    logic vld;
    logic go;
    key_t key;
  } link_t;

endpackage

// File: src/bmhq_if.sv
interface bmhq_in_if;
  import bmhq_pkg::*;
  logic valid;
  logic ready;
  logic op;
  key_t key_in;

  modport source (output valid, output op, output key_in, input ready);
  modport sink   (input valid, input op, input key_in, output ready);
endinterface

interface bmhq_out_if;
  import bmhq_pkg::*;
  logic                valid;
  logic                ready;
  key_t                removed_key;
  logic [StatusW-1:0]  status;
  logic [CountW-1:0]   entry_count;

  modport source (output valid, output removed_key, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input removed_key, input status, input entry_count,
                  output ready);
endinterface

// File: src/bmhq_cell.sv
module bmhq_cell import bmhq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cmd_t  cmd_i,
  input  link_t prev_i,
  input  link_t next_i,
  output link_t self_o
);

  logic vld_q, vld_d;
  key_t key_q, key_d;
  logic go;

  // Insert point lies at or below this cell when the new key is strictly smaller.
  assign go = !vld_q || (cmd_i.key < key_q);

  always_comb begin
    vld_d = vld_q;
    key_d = key_q;
    if (cmd_i.ins) begin
      vld_d = vld_q | prev_i.vld;
      if (go) begin
        key_d = prev_i.go ? prev_i.key : cmd_i.key;
      end
    end else if (cmd_i.rem) begin
      vld_d = next_i.vld;
      key_d = next_i.key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign self_o = '{vld: vld_q, go: go, key: key_q};

endmodule

// File: src/binary_min_heap_queue.sv
// Channel | Dir | Payload                              | Handshake
// in_i    | in  | op, key_in                           | valid/ready
// out_o   | out | removed_key, status, entry_count     | valid/ready
//
// For every item the whole sorted row of cells updates at once,
// each cell comparing against the broadcast key and its neighbours.
// The result lands in an output register; a new item is taken whenever that
// register is empty or being drained in the same cycle.
// Reset clears all valid bits and the count; key registers need no reset.
// A stall on out_o holds the result and blocks in_i until it is taken.
module binary_min_heap_queue import bmhq_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  bmhq_in_if.sink  in_i,
  bmhq_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  // Count of held keys, kept beside the row so full/empty is a plain compare.
  logic [CntW-1:0] count_q, count_d;
  logic            accept;
  logic            is_full, is_empty;
  cmd_t            cmd;

  // Result register.
  logic            out_vld_q;
  key_t            res_key_q, res_key_d;
  status_e         res_st_q, res_st_d;
  logic [CntW-1:0] res_cnt_q;

  link_t lnk [CAPACITY];

  assign is_full  = (count_q == CntW'(CAPACITY));
  assign is_empty = (count_q == '0);

  // Take a new item whenever the result slot is free or drains this cycle.
  assign in_i.ready = !out_vld_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    cmd.key = in_i.key_in;
    cmd.ins = accept && (op_e'(in_i.op) == OP_INSERT) && !is_full;
    cmd.rem = accept && (op_e'(in_i.op) == OP_REMOVE) && !is_empty;
  end

  always_comb begin
    count_d   = count_q;
    res_key_d = '0;
    res_st_d  = ST_DONE;
    unique case (op_e'(in_i.op))
      OP_INSERT: begin
        if (is_full) begin
          res_st_d = ST_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      OP_REMOVE: begin
        if (is_empty) begin
          res_st_d = ST_EMPTY;
        end else begin
          // Cell zero always holds the smallest key.
          res_key_d = lnk[0].key;
          count_d   = count_q - CntW'(1);
        end
      end
      default: ;
    endcase
  end

  // Row of cells, sorted ascending from cell zero; valid cells are contiguous.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    link_t prev, next;
    if (i == 0) begin : g_head
      // Head sees a filled, non-shifting neighbour: it takes the key itself.
      assign prev = '{vld: 1'b1, go: 1'b0, key: '0};
    end else begin : g_body
      assign prev = lnk[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      // Past the tail there is only empty space to shift in on remove.
      assign next = '{vld: 1'b0, go: 1'b1, key: '0};
    end else begin : g_mid
      assign next = lnk[i+1];
    end
    bmhq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .prev_i (prev),
      .next_i (next),
      .self_o (lnk[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q   <= count_d;
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Hold the payload until a new item replaces it.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_key_q <= res_key_d;
      res_st_q  <= res_st_d;
      res_cnt_q <= count_d;
    end
  end

  logic [CntW+CountW-1:0] cnt_ext;
  assign cnt_ext = {{CountW{1'b0}}, res_cnt_q};

  assign out_o.valid       = out_vld_q;
  assign out_o.removed_key = res_key_q;
  assign out_o.status      = res_st_q;
  assign out_o.entry_count = cnt_ext[CountW-1:0];

endmodule

// File: src/bmhq_chk.sv
module bmhq_chk import bmhq_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input key_t               removed_key_i,
  input logic [StatusW-1:0] status_i,
  input logic [CountW-1:0]  entry_count_i
);

  localparam logic [CAPACITY+CountW-1:0] CapExt = (CAPACITY + CountW)'(CAPACITY);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(removed_key_i)
      && $stable(status_i) && $stable(entry_count_i))
    else $error("result changed while stalled");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_EMPTY |-> entry_count_i == '0 && removed_key_i == '0)
    else $error("empty remove reports keys");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_FULL |-> entry_count_i == CapExt[CountW-1:0]
      && removed_key_i == '0)
    else $error("full insert reports wrong count");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i == ST_DONE || status_i == ST_EMPTY || status_i == ST_FULL)
    else $error("undefined status code");

endmodule

bind binary_min_heap_queue bmhq_chk #(.CAPACITY(CAPACITY)) u_bmhq_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .removed_key_i (out_o.removed_key),
  .status_i      (out_o.status),
  .entry_count_i (out_o.entry_count)
);

// File: tb/tb_top.sv
module tb_top;
  import bmhq_pkg::*;

  localparam int unsigned HeapCap    = 64;
  localparam int unsigned HalfPeriod = 6;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned StallLimit = 3000;
  localparam int unsigned TailCycles = 8;

  // One result item as the heap hands it back.
  typedef struct packed {
    key_t               removed_key;
    status_e            status;
    logic [CountW-1:0]  entry_count;
  } heap_result_t;

  logic clk_i;
  logic rst_ni;

  bmhq_in_if  in_if ();
  bmhq_out_if out_if ();

  binary_min_heap_queue #(
    .CAPACITY (HeapCap)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Shadow heap: our own array and fill level, advanced once per accepted item.
  key_t        heap_mem [HeapCap];
  int unsigned heap_fill;

  // Results still owed by the block, oldest first.
  heap_result_t heap_expect_q [$];

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  // Idling switches for each side, and a token that asks the receiver for a long hold-off.
  bit in_idle_en;
  bit out_idle_en;
  int hold_token;
  int seen_token = 0;
  int hold_left = 0;

  always #(HalfPeriod) clk_i = ~clk_i;

  // Apply one operation to the shadow heap and work out the result item it yields.
  task automatic predict_heap_op(input op_e op, input key_t key, output heap_result_t res);
    int unsigned pos;
    int unsigned up;
    int unsigned best;
    int unsigned lc;
    int unsigned rc;
    key_t        tmp;
    bit          settled;
    res.removed_key = '0;
    res.status      = ST_DONE;
    if (op == OP_INSERT) begin
      if (heap_fill >= HeapCap) begin
        // Full: drop the key, heap untouched.
        res.status = ST_FULL;
      end else begin
        pos = heap_fill;
        heap_mem[pos] = key;
        heap_fill++;
        settled = 1'b0;
        // Bubble up while strictly smaller than the parent; equal keys stay put.
        while (pos > 0 && !settled) begin
          up = (pos - 1) / 2;
          if (heap_mem[pos] < heap_mem[up]) begin
            tmp           = heap_mem[pos];
            heap_mem[pos] = heap_mem[up];
            heap_mem[up]  = tmp;
            pos           = up;
          end else begin
            settled = 1'b1;
          end
        end
      end
    end else begin
      if (heap_fill == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.removed_key = heap_mem[0];
        heap_fill--;
        heap_mem[0] = heap_mem[heap_fill];
        pos     = 0;
        settled = 1'b0;
        // Sift down toward the smaller child; the left one wins a tie.
        while (!settled) begin
          best = pos;
          lc   = 2 * pos + 1;
          rc   = 2 * pos + 2;
          if (lc < heap_fill && heap_mem[lc] < heap_mem[best]) best = lc;
          if (rc < heap_fill && heap_mem[rc] < heap_mem[best]) best = rc;
          if (best == pos) begin
            settled = 1'b1;
          end else begin
            tmp            = heap_mem[pos];
            heap_mem[pos]  = heap_mem[best];
            heap_mem[best] = tmp;
            pos            = best;
          end
        end
      end
    end
    res.entry_count = heap_fill[CountW-1:0];
  endtask

  // Keys: half wide random, with clusters of small values to force equal keys,
  // and the extremes of the signed range.
  function automatic key_t pick_key();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return key_t'($urandom);
      5, 6: return key_t'(int'($urandom_range(16)) - 8);
      7: begin
        case ($urandom_range(5))
          0:       return key_t'(32'h8000_0000);
          1:       return key_t'(32'h7fff_ffff);
          2:       return key_t'(32'h0000_0000);
          3:       return key_t'(32'hffff_ffff);
          4:       return key_t'(32'h8000_0001);
          default: return key_t'(32'h7fff_fffe);
        endcase
      end
      default: return key_t'(int'($urandom_range(2000)) - 1000);
    endcase
  endfunction

  // Offer one item, hold it until the block takes it, then record what it owes us.
  // valid is left high; a wait for results lowers it, as may the idle gaps of the next call.
  task automatic send_item(input op_e op, input key_t key);
    heap_result_t res;
    if (in_idle_en) begin
      while ($urandom_range(99) < 36) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_if.valid  <= 1'b1;
    in_if.op     <= op;
    in_if.key_in <= key;
    do @(posedge clk_i); while (!in_if.ready);
    predict_heap_op(op, key, res);
    heap_expect_q = {heap_expect_q, res};
  endtask

  // Drop valid and hold until every owed result has come back.
  task automatic wait_all_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (heap_expect_q.size() != 0);
  endtask

  // Extremes of the key range, equal keys, and removes on an empty heap.
  task automatic test_directed();
    send_item(OP_REMOVE, key_t'(32'h1234_5678));
    send_item(OP_REMOVE, key_t'(32'hffff_ffff));
    send_item(OP_INSERT, key_t'(32'h7fff_ffff));
    send_item(OP_INSERT, key_t'(32'h8000_0000));
    send_item(OP_INSERT, key_t'(32'h0000_0000));
    send_item(OP_INSERT, key_t'(32'hffff_ffff));
    send_item(OP_INSERT, key_t'(32'h0000_0000));
    send_item(OP_INSERT, key_t'(32'h8000_0000));
    send_item(OP_INSERT, key_t'(32'h0000_0005));
    send_item(OP_INSERT, key_t'(32'h0000_0005));
    send_item(OP_INSERT, key_t'(32'h0000_0005));
    repeat (9) send_item(OP_REMOVE, key_t'(32'h0));
    // One past empty: heap must report it and stay at zero.
    send_item(OP_REMOVE, key_t'(32'h0));
    send_item(OP_INSERT, key_t'(32'h5555_aaaa));
    send_item(OP_REMOVE, key_t'(32'h0));
  endtask

  // Phases that lean towards filling, draining or neither, so the heap
  // keeps hitting both full and empty with random content in between.
  task automatic test_random_walk(input int unsigned n_items);
    int unsigned sent;
    int unsigned span;
    int unsigned ins_pct;
    int unsigned k;
    sent = 0;
    while (sent < n_items) begin
      span = $urandom_range(150, 40);
      case ($urandom_range(2))
        0:       ins_pct = 85;
        1:       ins_pct = 15;
        default: ins_pct = 50;
      endcase
      for (k = 0; k < span && sent < n_items; k++) begin
        send_item(($urandom_range(99) < ins_pct) ? OP_INSERT : OP_REMOVE, pick_key());
        sent++;
      end
    end
  endtask

  // Freeze the receiver and keep offering; the output register fills and in_i stalls.
  task automatic test_backpressure();
    int unsigned k;
    hold_token++;
    for (k = 0; k < 40; k++) begin
      send_item(($urandom_range(99) < 70) ? OP_INSERT : OP_REMOVE, pick_key());
    end
  endtask

  // Pause until every owed result is in, then empty the heap and go two past.
  task automatic test_pause_and_drain();
    int unsigned n_left;
    wait_all_results();
    n_left = heap_fill + 2;
    repeat (n_left) send_item(OP_REMOVE, pick_key());
  endtask

  // Receiver: random ready, or a long hold-off when the token moves.
  always @(posedge clk_i) begin
    if (hold_token != seen_token) begin
      seen_token   <= hold_token;
      hold_left    <= HoldCycles;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (out_idle_en) begin
      out_if.ready <= ($urandom_range(99) >= 36);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Compare every accepted result item against the oldest expectation.
  always @(posedge clk_i) begin
    heap_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (heap_expect_q.size() == 0) begin
        $error("result item with nothing expected: removed_key %0d status %0d count %0d",
               out_if.removed_key, out_if.status, out_if.entry_count);
        mismatch_count++;
      end else begin
        want = heap_expect_q.pop_front();
        if (out_if.removed_key !== want.removed_key) begin
          $error("removed_key: expected %0d, got %0d", want.removed_key, out_if.removed_key);
          mismatch_count++;
        end
        if (out_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_if.status);
          mismatch_count++;
        end
        if (out_if.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count,
                 out_if.entry_count);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: give up when neither side has moved an item for too long.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    heap_fill      = 0;
    hold_token     = 0;
    in_idle_en     = 1'b1;
    out_idle_en    = 1'b1;
    in_if.valid    = 1'b0;
    in_if.op       = OP_INSERT;
    in_if.key_in   = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_walk(500);
    // Stretch with both sides flat out.
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    test_random_walk(250);
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    test_backpressure();
    test_random_walk(550);
    test_pause_and_drain();
    test_random_walk(100);

    wait_all_results();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
